// ===== rtl/multi_timer_bank_defines.svh =====
// ---------------------------------------------------------------------------
// Timer bank assertion macros
// Concurrent assertion wrappers that drop out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef MULTI_TIMER_BANK_DEFINES_SVH
`define MULTI_TIMER_BANK_DEFINES_SVH
`ifndef SYNTH
`define MTB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("lbl");
`define MTB_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error("lbl");
`else
`define MTB_ASSERT(lbl, clk, rstn, prop)
`define MTB_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== rtl/mtb_pkg.sv =====
// ---------------------------------------------------------------------------
// Timer bank package
// Shared sizes, codes and the slot record type.
// ---------------------------------------------------------------------------
package mtb_pkg;
  localparam int MaxTimers = 16;
  localparam int SlotW = $clog2(MaxTimers + 1);

  localparam logic [3:0] CmdTick = 4'd0;
  localparam logic [3:0] CmdAdd = 4'd1;
  localparam logic [3:0] CmdPause = 4'd2;
  localparam logic [3:0] CmdResume = 4'd3;
  localparam logic [3:0] CmdRemove = 4'd4;
  localparam logic [3:0] CmdPauseAll = 4'd5;
  localparam logic [3:0] CmdResumeAll = 4'd6;
  localparam logic [3:0] CmdRemoveAll = 4'd7;
  localparam logic [3:0] CmdQuery = 4'd8;

  localparam logic [3:0] KindAck = 4'd0;
  localparam logic [3:0] KindAdded = 4'd1;
  localparam logic [3:0] KindNotFound = 4'd2;
  localparam logic [3:0] KindFull = 4'd3;
  localparam logic [3:0] KindProgress = 4'd4;
  localparam logic [3:0] KindExpired = 4'd5;
  localparam logic [3:0] KindEvery = 4'd6;
  localparam logic [3:0] KindTickDone = 4'd7;
  localparam logic [3:0] KindQuery = 4'd8;

  typedef struct packed {
    logic        valid;
    logic [15:0] id;
    logic [31:0] elapsed;
    logic [31:0] duration;
    logic        paused;
    logic        looping;
    logic        use_scale;
    logic        every;
    logic        updater;
  } slot_t;

  // Per-cell actions: rotate from the neighbor, set or clear pause, and write.
  typedef struct packed {
    logic rotate;
    logic set_pause;
    logic clr_pause;
    logic write;
  } cell_ctl_t;
endpackage

// ===== rtl/mtb_cell.sv =====
// ---------------------------------------------------------------------------
// Timer bank cell
// Holds one timer record; loads it from its neighbor while rotating or from wr_i when written.
// ---------------------------------------------------------------------------
module mtb_cell import mtb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  slot_t     prev_i,
  input  slot_t     wr_i,
  output slot_t     slot_o
);
  slot_t slot_q, slot_d;

  always_comb begin
    slot_d = slot_q;
    if (ctl_i.rotate) begin
      slot_d = prev_i;
    end
    if (ctl_i.write) begin
      slot_d = wr_i;
    end
    if (ctl_i.set_pause && slot_d.valid) begin
      slot_d.paused = 1'b1;
    end
    if (ctl_i.clr_pause) begin
      slot_d.paused = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;
endmodule

// ===== rtl/multi_timer_bank.sv =====
// ---------------------------------------------------------------------------
// Multi timer bank
// An ordered ring of timer cells; commands rotate the ring past one head.
// ---------------------------------------------------------------------------
// Channel  Dir  Fields (tdata low to high)
// s_axis   in   command, timer_id, duration, looping, use_scale, every_frame,
//               updater, scaled_delta, unscaled_delta
// m_axis   out  kind, event_id, elapsed_out, duration_out, paused_out,
//               looping_out; tlast = last
// Tick, add and the single-timer commands rotate the ring of MaxTimers cells
// once, one cell per cycle while the output register can take a beat; the last
// beat follows the rotation. All-timer and unknown commands skip the rotation.
// Each rotation step waits while the output register holds a beat that the
// sink has not taken. Reset empties the bank at once.
module multi_timer_bank import mtb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,   // command, timer_id, duration, looping,
                                       // use_scale, every_frame, updater,
                                       // scaled_delta, unscaled_delta
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata,   // kind, event_id, elapsed_out,
                                       // duration_out, paused_out, looping_out
  output logic         m_axis_tlast
);
  `include "multi_timer_bank_defines.svh"

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun = 2'd1;
  localparam logic [1:0] StFinal = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [3:0]       cmd_q;
  logic [15:0]      tid_q;
  logic [31:0]      dur_q, sd_q, ud_q;
  logic [3:0]       fl_q;
  logic [SlotW-1:0] step_q, step_d;
  logic [SlotW-1:0] cnt_q, cnt_d;
  logic             found_q, found_d;
  logic [15:0]      next_id_q, next_id_d;
  logic             ov_q, ov_d;
  logic [87:0]      od_q, od_d;
  logic             ol_q, ol_d;

  slot_t     slot_w [MaxTimers];
  cell_ctl_t ctl_w [MaxTimers];
  slot_t     head_new;
  slot_t     add_rec;
  logic      head_write;

  slot_t       h;
  logic [31:0] delta;
  logic [32:0] sum;
  logic [31:0] el_sat;
  logic        exp;
  logic        out_free;
  logic        step_go;
  logic        emit;
  logic [3:0]  e_kind;
  logic [15:0] e_id;
  logic [31:0] e_el, e_du;
  logic        e_p, e_l;

  assign h = slot_w[0];
  assign out_free = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && out_free;

  assign delta = h.use_scale ? sd_q : ud_q;
  assign sum = {1'b0, h.elapsed} + {1'b0, delta};
  assign el_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign exp = el_sat >= h.duration;

  assign add_rec = '{valid: 1'b1, id: next_id_q, elapsed: 32'd0, duration: dur_q,
                     paused: 1'b0, looping: fl_q[0], use_scale: fl_q[1],
                     every: fl_q[2], updater: fl_q[3]};

  // The ring rotates toward index 0; the head record re-enters at the tail.
  always_comb begin
    head_new = h;
    emit = 1'b0;
    e_kind = KindAck;
    e_id = 16'd0;
    e_el = 32'd0;
    e_du = 32'd0;
    e_p = 1'b0;
    e_l = 1'b0;
    found_d = found_q;
    step_go = (state_q == StRun) && out_free;
    if (step_go && h.valid) begin
      unique case (cmd_q)
        CmdTick: begin
          if (!h.paused) begin
            head_new.elapsed = el_sat;
            if (h.updater) begin
              emit = 1'b1;
              e_kind = KindProgress;
              e_id = h.id;
              e_el = el_sat;
            end else if (exp || h.every) begin
              emit = 1'b1;
              e_kind = exp ? KindExpired : KindEvery;
              e_id = h.id;
            end
            if (exp) begin
              if (h.looping) begin
                head_new.elapsed = el_sat - h.duration;
              end else begin
                head_new.valid = 1'b0;
              end
            end
          end
        end
        CmdPause, CmdResume, CmdRemove, CmdQuery: begin
          if (!found_q && h.id == tid_q) begin
            found_d = 1'b1;
            if (cmd_q == CmdPause) begin
              head_new.paused = 1'b1;
            end else if (cmd_q == CmdResume) begin
              head_new.paused = 1'b0;
            end else if (cmd_q == CmdRemove) begin
              head_new.valid = 1'b0;
            end else begin
              e_el = h.elapsed;
              e_du = h.duration;
              e_p = h.paused;
              e_l = h.looping;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Invalid records are squeezed out as they pass the head: valid ones are
  // written at position remain + cnt, behind the kept ones; the list stays ordered.
  always_comb begin
    for (int i = 0; i < MaxTimers; i++) begin
      ctl_w[i] = '{rotate: 1'b0, set_pause: 1'b0, clr_pause: 1'b0, write: 1'b0};
    end
    if (state_q == StFinal && cmd_q == CmdPauseAll) begin
      for (int i = 0; i < MaxTimers; i++) ctl_w[i].set_pause = 1'b1;
    end
    if (state_q == StFinal && cmd_q == CmdResumeAll) begin
      for (int i = 0; i < MaxTimers; i++) ctl_w[i].clr_pause = 1'b1;
    end
    if (step_go) begin
      for (int i = 0; i < MaxTimers; i++) ctl_w[i].rotate = 1'b1;
    end
  end

  slot_t tail_in [MaxTimers];
  always_comb begin
    for (int i = 0; i < MaxTimers; i++) begin
      if (i == MaxTimers - 1) begin
        tail_in[i] = '0;
      end else begin
        tail_in[i] = slot_w[i+1];
      end
    end
  end

  // Record written into the compacted position: the head record in a rotation step, or the added timer.
  slot_t wr_rec;
  always_comb begin
    wr_rec = head_new;
    head_write = step_go && head_new.valid;
    if (state_q == StFinal && cmd_q == CmdAdd && cnt_q != SlotW'(MaxTimers)) begin
      wr_rec = add_rec;
      head_write = 1'b1;
    end
  end

  // The step counter tells where the squeezed list ends inside the ring.
  logic [SlotW-1:0] remain;
  assign remain = SlotW'(MaxTimers) - step_q - SlotW'(1);

  for (genvar g = 0; g < MaxTimers; g++) begin : g_cell
    cell_ctl_t c;
    always_comb begin
      c = ctl_w[g];
      if (head_write && state_q == StRun && SlotW'(g) == remain + cnt_q) begin
        c.write = 1'b1;
      end
      if (head_write && state_q == StFinal && SlotW'(g) == cnt_q) begin
        c.write = 1'b1;
      end
      if (state_q == StFinal && cmd_q == CmdRemoveAll) begin
        c.write = 1'b1;
      end
    end
    slot_t w;
    assign w = (state_q == StFinal && cmd_q == CmdRemoveAll) ? slot_t'('0) : wr_rec;
    mtb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (c),
      .prev_i (tail_in[g]),
      .wr_i   (w),
      .slot_o (slot_w[g])
    );
  end

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    cnt_d = cnt_q;
    next_id_d = next_id_q;
    ov_d = ov_q && !m_axis_tready;
    od_d = od_q;
    ol_d = ol_q;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          step_d = '0;
          cnt_d = '0;
          if (s_axis_tdata[3:0] == CmdPauseAll || s_axis_tdata[3:0] == CmdResumeAll ||
              s_axis_tdata[3:0] == CmdRemoveAll || s_axis_tdata[3:0] > CmdQuery) begin
            state_d = StFinal;
          end else begin
            state_d = StRun;
          end
        end
      end
      StRun: begin
        if (step_go) begin
          if (head_write) cnt_d = cnt_q + SlotW'(1);
          if (emit) begin
            ov_d = 1'b1;
            od_d = {2'b00, e_l, e_p, e_du, e_el, e_id, e_kind};
            ol_d = 1'b0;
          end
          step_d = step_q + SlotW'(1);
          if (step_q == SlotW'(MaxTimers - 1)) state_d = StFinal;
        end
      end
      StFinal: begin
        if (out_free) begin
          state_d = StIdle;
          ov_d = 1'b1;
          ol_d = 1'b1;
          od_d = '0;
          priority case (cmd_q)
            CmdTick: od_d[3:0] = KindTickDone;
            CmdAdd: begin
              if (cnt_q == SlotW'(MaxTimers)) begin
                od_d[3:0] = KindFull;
              end else begin
                od_d[19:0] = {next_id_q, KindAdded};
                next_id_d = next_id_q + 16'd1;
              end
            end
            CmdPause, CmdResume, CmdRemove: begin
              od_d[19:0] = {tid_q, found_q ? KindAck : KindNotFound};
            end
            CmdQuery: od_d = found_q ? od_q : {68'd0, tid_q, KindNotFound};
            default: od_d[3:0] = KindAck;
          endcase
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Query data is staged in its own register until the final beat.
  logic [87:0] qinfo_q;
  always_ff @(posedge clk_i) begin
    if (step_go && found_d && !found_q && cmd_q == CmdQuery) begin
      qinfo_q <= {2'b00, e_l, e_p, e_du, e_el, tid_q, KindQuery};
    end
  end

  logic [87:0] od_fix;
  assign od_fix = (state_q == StFinal && cmd_q == CmdQuery && found_q) ? qinfo_q : od_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q <= '0;
      cnt_q <= '0;
      found_q <= 1'b0;
      next_id_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      cnt_q <= cnt_d;
      found_q <= (state_q == StIdle) ? 1'b0 : found_d;
      next_id_q <= next_id_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_fix;
    ol_q <= ol_d;
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tdata[3:0];
      tid_q <= s_axis_tdata[19:4];
      dur_q <= s_axis_tdata[51:20];
      fl_q <= s_axis_tdata[55:52];
      sd_q <= s_axis_tdata[87:56];
      ud_q <= s_axis_tdata[119:88];
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = od_q;
  assign m_axis_tlast = ol_q;

  `MTB_ASSERT(a_ready_idle, clk_i, rst_ni, !s_axis_tready || state_q == StIdle)
  `MTB_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= SlotW'(MaxTimers))
  `MTB_ASSERT_NEXT(a_run_final, clk_i, rst_ni, state_q == StRun && step_go && step_q == SlotW'(MaxTimers - 1), state_q == StFinal)
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Timer bank testbench
// A directed table of commands followed by random command sequences. A
// behavioral copy of the bank predicts every output beat, and each beat is
// compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;
  import mtb_pkg::*;

  typedef struct packed {
    logic [31:0] unscaled;
    logic [31:0] scaled;
    logic        updater;
    logic        every;
    logic        use_scale;
    logic        looping;
    logic [31:0] duration;
    logic [15:0] timer_id;
    logic [3:0]  command;
  } cmd_beat_t;

  typedef struct packed {
    logic        last;
    logic        looping;
    logic        paused;
    logic [31:0] duration;
    logic [31:0] elapsed;
    logic [15:0] id;
    logic [3:0]  kind;
  } evt_t;

  typedef struct {
    cmd_beat_t cmd;
    logic      has_exp;
    logic [3:0] exp_kind;
    logic [15:0] exp_id;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;
  logic         m_axis_tlast;

  multi_timer_bank DUT (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state.
  slot_t       bank[MaxTimers];
  logic [15:0] id_counter;
  evt_t        pending_events[$];
  row_t        rows[$];
  int          errors = 0;
  bit          hold_off = 1'b0;

  function automatic void add_row(row_t rw);
    rows.insert(rows.size(), rw);
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    while (n < MaxTimers && bank[n].valid) n++;
    return n;
  endfunction

  function automatic int lookup(logic [15:0] id);
    for (int i = 0; i < MaxTimers && bank[i].valid; i++)
      if (bank[i].id == id) return i;
    return -1;
  endfunction

  function automatic void squeeze();
    int w;
    w = 0;
    for (int r = 0; r < MaxTimers; r++)
      if (bank[r].valid) begin
        bank[w] = bank[r];
        w++;
      end
    for (; w < MaxTimers; w++) bank[w].valid = 1'b0;
  endfunction

  function automatic void post(logic [3:0] kind, logic [15:0] id, logic [31:0] el,
                               logic [31:0] du, logic p, logic l, logic last);
    evt_t e;
    e = '{last: last, looping: l, paused: p, duration: du, elapsed: el, id: id,
          kind: kind};
    pending_events.insert(pending_events.size(), e);
  endfunction

  function automatic void predict_timer_bank(cmd_beat_t c);
    int n;
    int s;
    logic [31:0] d;
    logic [32:0] sum;
    logic [31:0] e;
    bit dropped;
    dropped = 1'b0;
    case (c.command)
      CmdTick: begin
        n = live_count();
        for (int i = 0; i < n; i++) begin
          if (bank[i].paused) continue;
          d = bank[i].use_scale ? c.scaled : c.unscaled;
          sum = {1'b0, bank[i].elapsed} + {1'b0, d};
          e = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          bank[i].elapsed = e;
          if (bank[i].updater) post(KindProgress, bank[i].id, e, '0, 1'b0, 1'b0, 1'b0);
          if (e >= bank[i].duration) begin
            if (!bank[i].updater) post(KindExpired, bank[i].id, '0, '0, 1'b0, 1'b0, 1'b0);
            if (bank[i].looping) bank[i].elapsed = e - bank[i].duration;
            else begin
              bank[i].valid = 1'b0;
              dropped = 1'b1;
            end
          end else if (bank[i].every && !bank[i].updater) begin
            post(KindEvery, bank[i].id, '0, '0, 1'b0, 1'b0, 1'b0);
          end
        end
        if (dropped) squeeze();
        post(KindTickDone, '0, '0, '0, 1'b0, 1'b0, 1'b1);
      end
      CmdAdd: begin
        n = live_count();
        if (n >= MaxTimers) post(KindFull, '0, '0, '0, 1'b0, 1'b0, 1'b1);
        else begin
          bank[n] = '{valid: 1'b1, id: id_counter, elapsed: '0, duration: c.duration,
                      paused: 1'b0, looping: c.looping, use_scale: c.use_scale,
                      every: c.every, updater: c.updater};
          post(KindAdded, id_counter, '0, '0, 1'b0, 1'b0, 1'b1);
          id_counter++;
        end
      end
      CmdPause, CmdResume, CmdRemove, CmdQuery: begin
        s = lookup(c.timer_id);
        if (s < 0) post(KindNotFound, c.timer_id, '0, '0, 1'b0, 1'b0, 1'b1);
        else if (c.command == CmdQuery)
          post(KindQuery, c.timer_id, bank[s].elapsed, bank[s].duration,
               bank[s].paused, bank[s].looping, 1'b1);
        else begin
          if (c.command == CmdPause) bank[s].paused = 1'b1;
          else if (c.command == CmdResume) bank[s].paused = 1'b0;
          else begin
            bank[s].valid = 1'b0;
            squeeze();
          end
          post(KindAck, c.timer_id, '0, '0, 1'b0, 1'b0, 1'b1);
        end
      end
      CmdPauseAll, CmdResumeAll: begin
        for (int i = 0; i < MaxTimers; i++)
          if (bank[i].valid) bank[i].paused = (c.command == CmdPauseAll);
        post(KindAck, '0, '0, '0, 1'b0, 1'b0, 1'b1);
      end
      CmdRemoveAll: begin
        for (int i = 0; i < MaxTimers; i++) bank[i].valid = 1'b0;
        post(KindAck, '0, '0, '0, 1'b0, 1'b0, 1'b1);
      end
      default: post(KindAck, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic cmd_beat_t make_cmd(logic [3:0] op, logic [15:0] id = '0,
                                         logic [31:0] dur = '0, logic [3:0] fl = '0,
                                         logic [31:0] sd = '0, logic [31:0] ud = '0);
    cmd_beat_t c;
    c = '{unscaled: ud, scaled: sd, updater: fl[3], every: fl[2], use_scale: fl[1],
          looping: fl[0], duration: dur, timer_id: id, command: op};
    return c;
  endfunction

  function automatic logic [15:0] pick_id();
    int n;
    n = live_count();
    if (n > 0 && $urandom_range(0, 3) != 0) return bank[$urandom_range(0, n - 1)].id;
    return 16'($urandom);
  endfunction

  function automatic cmd_beat_t random_cmd();
    int r;
    logic [31:0] dur;
    logic [31:0] sd;
    logic [31:0] ud;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 5))
      0: dur = 32'hFFFF_FFFF - $urandom_range(0, 3);
      1: dur = $urandom;
      default: dur = $urandom_range(0, 32'h0008_0000);
    endcase
    sd = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h0002_0000);
    ud = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h0002_0000);
    if (r < 40) return make_cmd(CmdTick, 16'($urandom), $urandom, 4'($urandom), sd, ud);
    if (r < 65) return make_cmd(CmdAdd, 16'($urandom), dur, 4'($urandom), $urandom,
                                $urandom);
    if (r < 72) return make_cmd(CmdPause, pick_id());
    if (r < 79) return make_cmd(CmdResume, pick_id());
    if (r < 85) return make_cmd(CmdRemove, pick_id());
    if (r < 93) return make_cmd(CmdQuery, pick_id());
    if (r < 95) return make_cmd(CmdPauseAll);
    if (r < 97) return make_cmd(CmdResumeAll);
    if (r < 98) return make_cmd(CmdRemoveAll);
    return make_cmd(4'($urandom_range(9, 15)), 16'($urandom));
  endfunction

  task automatic send_cmd(cmd_beat_t c);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
          ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_timer_bank(c);
  endtask

  // Sink side: random back-pressure with one long hold-off.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) m_axis_tready <= 1'b0;
      else if ($urandom_range(0, 19) == 0) m_axis_tready <= 1'b0;
      else m_axis_tready <= ($urandom_range(0, 3) != 0) || $urandom_range(0, 1);
    end
  end

  initial begin
    @(posedge rst_ni);
    repeat (200) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    evt_t got;
    evt_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tlast, m_axis_tdata[85:0]};
      if (pending_events.size() == 0) begin
        $error("unexpected beat: kind %0d id %0d", got.kind, got.id);
        errors++;
      end else begin
        want = pending_events.pop_front();
        if (got.kind != want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, got.kind); errors++;
        end
        if (got.id != want.id) begin
          $error("event_id: expected %0d, got %0d", want.id, got.id); errors++;
        end
        if (got.elapsed != want.elapsed) begin
          $error("elapsed_out: expected %h, got %h", want.elapsed, got.elapsed); errors++;
        end
        if (got.duration != want.duration) begin
          $error("duration_out: expected %h, got %h", want.duration, got.duration);
          errors++;
        end
        if (got.paused != want.paused) begin
          $error("paused_out: expected %0d, got %0d", want.paused, got.paused); errors++;
        end
        if (got.looping != want.looping) begin
          $error("looping_out: expected %0d, got %0d", want.looping, got.looping);
          errors++;
        end
        if (got.last != want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last); errors++;
        end
        if (m_axis_tdata[87:86] != 2'b00) begin
          $error("tdata pad: expected 0, got %0d", m_axis_tdata[87:86]); errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("multi_timer_bank test failed");
    $finish;
  end

  initial begin
    int idle;
    for (int i = 0; i < MaxTimers; i++) bank[i] = '0;
    id_counter = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row('{make_cmd(CmdTick), 1'b1, KindTickDone, 16'd0});
    add_row('{make_cmd(CmdQuery, 16'd0), 1'b1, KindNotFound, 16'd0});
    add_row('{make_cmd(CmdPause, 16'hFFFF), 1'b1, KindNotFound, 16'hFFFF});
    add_row('{make_cmd(CmdAdd, '0, 32'd0, 4'b0000), 1'b1, KindAdded, 16'd0});
    add_row('{make_cmd(CmdAdd, '0, 32'hFFFF_FFFF, 4'b0101), 1'b1, KindAdded, 16'd1});
    add_row('{make_cmd(CmdAdd, '0, 32'h0001_0000, 4'b1011), 1'b1, KindAdded, 16'd2});
    add_row('{make_cmd(CmdAdd, '0, 32'h0000_8000, 4'b1100), 1'b1, KindAdded, 16'd3});
    add_row('{make_cmd(CmdAdd, '0, 32'h0002_0000, 4'b0011), 1'b1, KindAdded, 16'd4});
    add_row('{make_cmd(CmdTick, '0, '0, '0, 32'h0000_4000, 32'h0000_C000), 1'b0, '0, '0});
    add_row('{make_cmd(CmdTick, '0, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0, '0});
    add_row('{make_cmd(CmdQuery, 16'd1), 1'b0, '0, '0});
    add_row('{make_cmd(CmdPause, 16'd4), 1'b0, '0, '0});
    add_row('{make_cmd(CmdTick, '0, '0, '0, 32'h0001_0000, 32'h0001_0000), 1'b0, '0, '0});
    add_row('{make_cmd(CmdResume, 16'd4), 1'b0, '0, '0});
    add_row('{make_cmd(CmdPauseAll), 1'b1, KindAck, 16'd0});
    add_row('{make_cmd(CmdQuery, 16'd4), 1'b0, '0, '0});
    add_row('{make_cmd(CmdResumeAll), 1'b1, KindAck, 16'd0});
    add_row('{make_cmd(CmdRemove, 16'd1), 1'b0, '0, '0});
    add_row('{make_cmd(4'd15, 16'hFFFF), 1'b1, KindAck, 16'd0});
    add_row('{make_cmd(CmdRemoveAll), 1'b1, KindAck, 16'd0});
    for (int i = 0; i < MaxTimers; i++)
      add_row('{make_cmd(CmdAdd, '0, 32'h0003_0000, 4'b0001), 1'b0, '0, '0});
    add_row('{make_cmd(CmdAdd), 1'b1, KindFull, 16'd0});
    add_row('{make_cmd(CmdTick, '0, '0, '0, 32'h0001_0000, 32'h0001_0000), 1'b0, '0, '0});

    foreach (rows[r]) begin
      send_cmd(rows[r].cmd);
      if (rows[r].has_exp &&
          (pending_events[pending_events.size() - 1].kind != rows[r].exp_kind ||
           pending_events[pending_events.size() - 1].id != rows[r].exp_id)) begin
        $error("table row %0d: kind expected %0d, id expected %0d", r, rows[r].exp_kind,
               rows[r].exp_id);
        errors++;
      end
    end

    for (int i = 0; i < 340; i++) send_cmd(random_cmd());
    s_axis_tvalid <= 1'b0;

    idle = 0;
    while (pending_events.size() != 0 && idle < 200000) begin
      @(posedge clk_i);
      idle++;
    end
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending_events.size() == 0) begin
      $display("multi_timer_bank test passed");
    end else begin
      $display("multi_timer_bank test failed");
    end
    $finish;
  end
endmodule
